>>> src/xxtea_block_cipher_assert.svh
// Assertion macros used by the checker file.
`ifndef XXTEA_BLOCK_CIPHER_ASSERT_SVH
`define XXTEA_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication.
`define XX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xxtea check failed");

// Next-cycle implication.
`define XX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xxtea check failed");

`endif

>>> src/xxtea_pkg.sv
`default_nettype none

package xxtea_pkg;

   localparam int MAX_WORDS = 64;
   localparam int IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int ROUND_W   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int WORD_W    = 32;

   localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ROUND_W-1:0] round_type;
   typedef logic [WORD_W-1:0]  word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_WORD0    = 3'd0,
      CSR_KEY_WORD1    = 3'd1,
      CSR_KEY_WORD2    = 3'd2,
      CSR_KEY_WORD3    = 3'd3,
      CSR_DECRYPT_MODE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      logic      wr_load;
      idx_type   wr_addr;
      logic      load_h;
      logic      load_w;
      logic      mix_en;
      logic      upd_en;
      logic      sum_init;
      logic      sum_add;
      logic      sum_sub;
      idx_type   p;
      round_type init_rounds;
   } dp_cmd_type;

   typedef struct packed {
      logic decrypt;
   } dp_status_type;

   // 6 + 52 / (n + 1), n = last word index
   function automatic round_type rounds_of(input idx_type n);
      logic [IDX_W:0] len;
      round_type r;
      len = {1'b0, n} + 1'b1;
      if (len >= 53)      r = 6'd6;
      else if (len >= 27) r = 6'd7;
      else if (len >= 18) r = 6'd8;
      else if (len >= 14) r = 6'd9;
      else if (len >= 11) r = 6'd10;
      else if (len >= 9)  r = 6'd11;
      else if (len == 8)  r = 6'd12;
      else if (len == 7)  r = 6'd13;
      else if (len == 6)  r = 6'd14;
      else if (len == 5)  r = 6'd16;
      else if (len == 4)  r = 6'd19;
      else if (len == 3)  r = 6'd23;
      else if (len == 2)  r = 6'd32;
      else                r = 6'd58;
      return r;
   endfunction

   function automatic word_type xx_mix(input word_type z, input word_type y,
                                       input word_type sum, input word_type key);
      word_type a;
      word_type b;
      a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      b = (sum ^ y) + (key ^ z);
      return a ^ b;
   endfunction

endpackage

`default_nettype wire

>>> src/xxtea_if.sv
`default_nettype none

interface xxtea_req_if import xxtea_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type block_word;
   logic     block_end;
   modport source(output valid, output block_word, output block_end, input ready);
   modport sink(input valid, input block_word, input block_end, output ready);
endinterface

interface xxtea_rsp_if import xxtea_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result_word;
   logic     result_end;
   modport source(output valid, output result_word, output result_end, input ready);
   modport sink(input valid, input result_word, input result_end, output ready);
endinterface

interface xxtea_csr_if import xxtea_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   word_type             data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/xxtea_block_cipher.sv
// channel  dir  handshake        payload
// req      in   valid / ready    block_word[31:0], block_end
// rsp      out  valid / ready    result_word[31:0], result_end
// csr      in   valid / ready    index[2:0], data[31:0]
//
// A block of L words is loaded one word per accepted req transfer. For L > 1 the
// setup, init1 and init2 states follow, then R = 6 + 52/L rounds, each a round step
// and, per word, a mix step and an update step on the word store. Each result word
// is read, then sent. Synchronous active-high reset; csr is always ready. req_ready
// is low from block end until the last result is taken; rsp stalls hold.
`default_nettype none

module xxtea_block_cipher import xxtea_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   xxtea_req_if.sink    req_chan,
   xxtea_rsp_if.source  rsp_chan,
   xxtea_csr_if.sink    csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_chan.ready = 1'b1;

   xxtea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_end   (req_chan.block_end),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_end   (rsp_chan.result_end),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xxtea_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_chan.block_word),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .rsp_word  (rsp_chan.result_word)
   );

endmodule

`default_nettype wire

>>> src/xxtea_ctrl.sv
`default_nettype none

module xxtea_ctrl import xxtea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_end,
   output logic          req_ready,
   output logic          rsp_valid,
   output logic          rsp_end,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SETUP,
      ST_INIT1,
      ST_INIT2,
      ST_ROUND,
      ST_MIX,
      ST_UPD,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   state_type state_ff;
   idx_type   wr_idx_ff;
   idx_type   n_ff;
   idx_type   p_ff;
   round_type rounds_ff;
   logic      rsp_valid_ff;
   logic      rsp_end_ff;

   logic    dec;
   logic    last_step;
   logic    load_done;
   idx_type p_start;
   idx_type p_next;
   idx_type a_idx;

   assign dec       = status.decrypt;
   assign last_step = dec ? (p_ff == '0) : (p_ff == n_ff);
   assign p_start   = dec ? n_ff : '0;
   assign p_next    = last_step ? p_start : (dec ? p_ff - 1'b1 : p_ff + 1'b1);
   assign load_done = req_end || (wr_idx_ff == IDX_W'(MAX_WORDS - 1));

   // neighbor read for the step at p_next
   always_comb begin
      if (dec) begin
         a_idx = (p_next == '0) ? n_ff : p_next - 1'b1;
      end else begin
         a_idx = (p_next == n_ff) ? '0 : p_next + 1'b1;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_end   = rsp_end_ff;

   always_comb begin
      cmd             = '0;
      cmd.p           = p_ff;
      cmd.rd_addr     = p_ff;
      cmd.wr_addr     = p_ff;
      cmd.init_rounds = rounds_of(n_ff);
      unique case (state_ff)
         ST_LOAD: begin
            cmd.wr_en   = req_valid;
            cmd.wr_load = 1'b1;
            cmd.wr_addr = wr_idx_ff;
         end
         ST_SETUP: begin
            cmd.sum_init = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = dec ? '0 : n_ff;
         end
         ST_INIT1: begin
            cmd.load_h  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = dec ? n_ff : '0;
         end
         ST_INIT2: begin
            cmd.load_w  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = dec ? n_ff - 1'b1 : IDX_W'(1);
         end
         ST_ROUND: begin
            cmd.sum_add = !dec;
         end
         ST_MIX: begin
            cmd.mix_en = 1'b1;
         end
         ST_UPD: begin
            cmd.upd_en  = 1'b1;
            cmd.wr_en   = 1'b1;
            cmd.sum_sub = dec && last_step;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = a_idx;
         end
         ST_OUT_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_OUT_SEND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         wr_idx_ff    <= '0;
         n_ff         <= '0;
         p_ff         <= '0;
         rounds_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_end_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  if (load_done) begin
                     n_ff      <= wr_idx_ff;
                     wr_idx_ff <= '0;
                     p_ff      <= '0;
                     state_ff  <= (wr_idx_ff == '0) ? ST_OUT_RD : ST_SETUP;
                  end else begin
                     wr_idx_ff <= wr_idx_ff + 1'b1;
                  end
               end
            end
            ST_SETUP: begin
               rounds_ff <= rounds_of(n_ff);
               state_ff  <= ST_INIT1;
            end
            ST_INIT1: state_ff <= ST_INIT2;
            ST_INIT2: state_ff <= ST_ROUND;
            ST_ROUND: begin
               rounds_ff <= rounds_ff - 1'b1;
               p_ff      <= p_start;
               state_ff  <= ST_MIX;
            end
            ST_MIX: state_ff <= ST_UPD;
            ST_UPD: begin
               if (!last_step) begin
                  p_ff     <= p_next;
                  state_ff <= ST_MIX;
               end else if (rounds_ff == '0) begin
                  p_ff     <= '0;
                  state_ff <= ST_OUT_RD;
               end else begin
                  p_ff     <= p_next;
                  state_ff <= ST_ROUND;
               end
            end
            ST_OUT_RD: begin
               rsp_valid_ff <= 1'b1;
               rsp_end_ff   <= (p_ff == n_ff);
               state_ff     <= ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_end_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     p_ff     <= p_ff + 1'b1;
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> src/xxtea_dp.sv
`default_nettype none

module xxtea_dp import xxtea_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  word_type             req_word,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  word_type             csr_data,
   output word_type             rsp_word
);

   word_type key_ff [4];
   logic     mode_ff;

   word_type store [MAX_WORDS];
   word_type rd_ff;
   word_type h_ff;
   word_type w_ff;
   word_type mix_ff;
   word_type sum_ff;

   word_type       wdata;
   word_type       new_word;
   word_type       z;
   word_type       y;
   logic [1:0]     kidx;
   logic [IDX_W+1:0] p_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_WORD0:    key_ff[0] <= csr_data;
            CSR_KEY_WORD1:    key_ff[1] <= csr_data;
            CSR_KEY_WORD2:    key_ff[2] <= csr_data;
            CSR_KEY_WORD3:    key_ff[3] <= csr_data;
            CSR_DECRYPT_MODE: mode_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign status.decrypt = mode_ff;

   // encrypt: z held, y read; decrypt: z read, y held
   assign z        = mode_ff ? rd_ff : h_ff;
   assign y        = mode_ff ? h_ff : rd_ff;
   assign p_ext    = {2'b00, cmd.p};
   assign kidx     = p_ext[1:0] ^ sum_ff[3:2];
   assign new_word = mode_ff ? w_ff - mix_ff : w_ff + mix_ff;
   assign wdata    = cmd.wr_load ? req_word : new_word;
   assign rsp_word = rd_ff;

   // word store, write-first on an address match
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store[cmd.wr_addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff <= (cmd.wr_en && cmd.wr_addr == cmd.rd_addr) ? wdata : store[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_init) begin
         sum_ff <= mode_ff ? WORD_W'(cmd.init_rounds) * DELTA : '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + DELTA;
      end else if (cmd.sum_sub) begin
         sum_ff <= sum_ff - DELTA;
      end

      if (cmd.mix_en) begin
         mix_ff <= xx_mix(z, y, sum_ff, key_ff[kidx]);
      end

      if (cmd.upd_en) begin
         h_ff <= new_word;
         w_ff <= rd_ff;
      end else begin
         if (cmd.load_h) begin
            h_ff <= rd_ff;
         end
         if (cmd.load_w) begin
            w_ff <= rd_ff;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/xxtea_block_cipher_checker.sv
`default_nettype none

`include "xxtea_block_cipher_assert.svh"

module xxtea_block_cipher_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end
);

   `XX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `XX_ASSERT_NOW(a_no_req_during_rsp, clock, reset, rsp_valid, !req_ready)
   `XX_ASSERT_NEXT(a_block_end_stops_req, clock, reset, req_valid && req_ready && req_end, !req_ready)
   `XX_ASSERT_NEXT(a_final_rsp_gap, clock, reset, rsp_valid && rsp_ready && rsp_end, !rsp_valid)

endmodule

bind xxtea_block_cipher xxtea_block_cipher_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_end   (req_chan.block_end),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_end   (rsp_chan.result_end)
);

`default_nettype wire
